@@ hdl/lsd_pkg.sv @@
`timescale 1ns / 1ps

package lsd_pkg;

   // panel geometry
   localparam int NumCommons     = 10;
   localparam int BytesPerRow    = 4;
   localparam int RowW           = (NumCommons > 1) ? $clog2(NumCommons) : 1;
   localparam int ColW           = $clog2(BytesPerRow);

   // time base
   localparam int TicksPerSecond = 1000;
   localparam int TickW          = (TicksPerSecond > 1) ? $clog2(TicksPerSecond + 1) : 1;
   localparam int SecW           = 31;
   localparam int RandW          = 8;

   // port widths fixed by the pin map
   localparam int IdxW  = 4;
   localparam int MaskW = 10;
   localparam int SegW  = 26;
   localparam int TickOutW = 10;

   // operation codes
   localparam logic OpTick  = 1'b0;
   localparam logic OpWrite = 1'b1;

   typedef logic [7:0] byte_type;
   typedef byte_type [BytesPerRow-1:0] row_type;

   typedef struct packed {
      logic [RowW-1:0]  sel;
      logic             phase;
      logic [TickW-1:0] tick;
      logic [SecW-1:0]  seconds;
      logic [RandW-1:0] random;
   } scan_info_type;

endpackage

@@ hdl/lsd_store.sv @@
`timescale 1ns / 1ps

module lsd_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [lsd_pkg::RowW-1:0]  wr_row,
   input  logic [lsd_pkg::ColW-1:0]  wr_col,
   input  lsd_pkg::byte_type         wr_data,
   input  logic                      rd_en,
   input  logic [lsd_pkg::RowW-1:0]  rd_row,
   output lsd_pkg::row_type          rd_data
);

   // display bytes, one row per common
   lsd_pkg::row_type mem [lsd_pkg::NumCommons];

   // per-byte written flags, a byte never written reads blank
   logic [lsd_pkg::BytesPerRow-1:0] written_ff [lsd_pkg::NumCommons];

   lsd_pkg::row_type                rd_ff;
   logic [lsd_pkg::BytesPerRow-1:0] rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_col] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < lsd_pkg::NumCommons; r++) begin
            written_ff[r] <= '0;
         end
         rd_written_ff <= '0;
      end else begin
         if (wr_en) begin
            written_ff[wr_row][wr_col] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_row];
         end
      end
   end

   always_comb begin
      for (int b = 0; b < lsd_pkg::BytesPerRow; b++) begin
         rd_data[b] = rd_written_ff[b] ? rd_ff[b] : '0;
      end
   end

endmodule

@@ hdl/lsd_scan.sv @@
`timescale 1ns / 1ps

module lsd_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   output lsd_pkg::scan_info_type info
);

   logic [lsd_pkg::RowW-1:0]  scan_ff,  scan_in;
   logic                      phase_ff, phase_in;
   logic [lsd_pkg::TickW-1:0] tick_ff,  tick_in;
   logic [lsd_pkg::SecW-1:0]  sec_ff,   sec_in;
   logic [lsd_pkg::RandW-1:0] rand_ff,  rand_in;

   always_comb begin
      rand_in = rand_ff + 1'b1;
      sec_in  = sec_ff;
      if (tick_ff == lsd_pkg::TickW'(lsd_pkg::TicksPerSecond - 1)) begin
         tick_in = '0;
         sec_in  = sec_ff + 1'b1;
      end else begin
         tick_in = tick_ff + 1'b1;
      end
      phase_in = phase_ff;
      if (scan_ff == lsd_pkg::RowW'(lsd_pkg::NumCommons - 1)) begin
         scan_in  = '0;
         phase_in = ~phase_ff;
      end else begin
         scan_in = scan_ff + 1'b1;
      end
   end

   // common and phase in force during this tick, counters after it
   assign info.sel     = scan_ff;
   assign info.phase   = phase_ff;
   assign info.tick    = tick_in;
   assign info.seconds = sec_in;
   assign info.random  = rand_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         phase_ff <= 1'b0;
         tick_ff  <= '0;
         sec_ff   <= '0;
         rand_ff  <= '0;
      end else if (advance) begin
         scan_ff  <= scan_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         sec_ff   <= sec_in;
         rand_ff  <= rand_in;
      end
   end

endmodule

@@ hdl/multiplexed_lcd_scan_driver_unit.sv @@
`timescale 1ns / 1ps

// channel   dir  ports                                   beat
// req       in   req_valid/req_stall, operation..data     one tick or one byte write
// rsp       out  rsp_valid/rsp_stall, common_index..      one per tick, none per write
//
// one beat per cycle while req_stall is low, writes and ticks alike; a tick result passes
// through the store read register, then the output register, after its beat
// the display row is read from a synchronous memory, and the output register follows it
// reset is synchronous; per-byte written flags make the store read blank at once, no sweep
// req_stall rises only while both the read stage and the output register hold beats
// and rsp_stall is high

module multiplexed_lcd_scan_driver_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [3:0]                    req_row,
   input  logic [1:0]                    req_column,
   input  logic [7:0]                    req_data,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lsd_pkg::IdxW-1:0]      rsp_common_index,
   output logic                          rsp_polarity,
   output logic [lsd_pkg::MaskW-1:0]     rsp_group_a_drive,
   output logic [lsd_pkg::MaskW-1:0]     rsp_group_a_level,
   output logic [lsd_pkg::MaskW-1:0]     rsp_group_b_drive,
   output logic [lsd_pkg::MaskW-1:0]     rsp_group_b_level,
   output logic [lsd_pkg::SegW-1:0]      rsp_segment_drive,
   output logic                          rsp_segment_level,
   output logic [lsd_pkg::TickOutW-1:0]  rsp_tick_count,
   output logic [lsd_pkg::SecW-1:0]      rsp_seconds,
   output logic [lsd_pkg::RandW-1:0]     rsp_random_byte
);

   // handshake and pipeline control
   logic req_take, tick_take, write_take;
   logic s1_valid_ff, out_valid_ff;
   logic out_load, s1_adv;

   assign out_load  = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s1_adv    = !s1_valid_ff || out_load;
   assign req_stall = !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign tick_take  = req_take && (req_operation == lsd_pkg::OpTick);
   assign write_take = req_take && (req_operation == lsd_pkg::OpWrite)
                       && (32'(req_row) < lsd_pkg::NumCommons);

   // scan position and time base
   lsd_pkg::scan_info_type info;

   lsd_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (tick_take),
      .info    (info)
   );

   // display store, row of the current common read on the tick beat
   lsd_pkg::row_type row_bytes;

   lsd_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (write_take),
      .wr_row  (req_row[lsd_pkg::RowW-1:0]),
      .wr_col  (req_column[lsd_pkg::ColW-1:0]),
      .wr_data (req_data),
      .rd_en   (tick_take),
      .rd_row  (info.sel),
      .rd_data (row_bytes)
   );

   // read stage: tick context waits here for the row data
   lsd_pkg::scan_info_type s1_info_ff;

   always_ff @(posedge clock) begin
      if (tick_take) begin
         s1_info_ff <= info;
      end
   end

   // masks for the selected common
   logic [lsd_pkg::NumCommons-1:0] sel_bit;
   logic [lsd_pkg::NumCommons-1:0] all_commons;
   logic [lsd_pkg::SegW-1:0]       segs;

   always_comb begin
      sel_bit = '0;
      sel_bit[s1_info_ff.sel] = 1'b1;
      all_commons = '1;
      // pin map: byte0, low nibble of byte1, byte2, low six bits of byte3
      segs = {row_bytes[3][5:0], row_bytes[2], row_bytes[1][3:0], row_bytes[0]};
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= tick_take;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_common_index  <= lsd_pkg::IdxW'(s1_info_ff.sel);
         rsp_polarity      <= s1_info_ff.phase;
         rsp_group_b_drive <= lsd_pkg::MaskW'(sel_bit);
         rsp_segment_drive <= segs;
         rsp_tick_count    <= lsd_pkg::TickOutW'(s1_info_ff.tick);
         rsp_seconds       <= s1_info_ff.seconds;
         rsp_random_byte   <= s1_info_ff.random;
         if (!s1_info_ff.phase) begin
            // positive phase: all commons driven, selected one low, lit segments high
            rsp_group_a_drive <= lsd_pkg::MaskW'(all_commons);
            rsp_group_a_level <= lsd_pkg::MaskW'(all_commons & ~sel_bit);
            rsp_group_b_level <= '0;
            rsp_segment_level <= 1'b1;
         end else begin
            // negative phase: group a floats, group b drives the selected common high
            rsp_group_a_drive <= '0;
            rsp_group_a_level <= '0;
            rsp_group_b_level <= lsd_pkg::MaskW'(sel_bit);
            rsp_segment_level <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule
